// ===== sv/bgrg_pkg.sv =====
// ----------------------------------------------------------------------------
// bgrg_pkg
// Shared types, register codes and the shape table of the box glyph
// rectangle generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bgrg_pkg;

	localparam int CP_W     = 21;
	localparam int GRID_W   = 10;
	localparam int CW_W     = 7;
	localparam int CH_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;
	localparam int X_W      = 21;
	localparam int Y_W      = 22;
	localparam int W_W      = 11;
	localparam int H_W      = 12;
	localparam int FR_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PX_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PX_HEIGHT = 1'd1;

	localparam logic [CW_W-1:0] CW_RESET = 7'd8;
	localparam logic [CW_W-1:0] CW_MAX   = 7'd64;
	localparam logic [CH_W-1:0] CH_RESET = 8'd16;
	localparam logic [CH_W-1:0] CH_MAX   = 8'd128;

	// Rectangle in sixteenths of the cell
	typedef struct packed {
		logic [FR_W-1:0] x;
		logic [FR_W-1:0] y;
		logic [FR_W-1:0] w;
		logic [FR_W-1:0] h;
	} frect_t;

	typedef struct packed {
		logic   hit;
		logic   two;
		frect_t r0;
		frect_t r1;
	} shape_t;

	localparam frect_t R_NONE = '{5'd0, 5'd0, 5'd0, 5'd0};
	localparam frect_t R_HL   = '{5'd0, 5'd7, 5'd16, 5'd2};
	localparam frect_t R_HH   = '{5'd0, 5'd6, 5'd16, 5'd4};
	localparam frect_t R_VL   = '{5'd7, 5'd0, 5'd2, 5'd16};
	localparam frect_t R_VH   = '{5'd6, 5'd0, 5'd4, 5'd16};
	localparam frect_t R_SL   = '{5'd0, 5'd7, 5'd9, 5'd2};
	localparam frect_t R_SR   = '{5'd7, 5'd7, 5'd9, 5'd2};
	localparam frect_t R_SU   = '{5'd7, 5'd0, 5'd2, 5'd9};
	localparam frect_t R_SD   = '{5'd7, 5'd7, 5'd2, 5'd9};

	function automatic frect_t mk_rect(input int x, input int y, input int w, input int h);
		frect_t r;
		r.x = FR_W'(x);
		r.y = FR_W'(y);
		r.w = FR_W'(w);
		r.h = FR_W'(h);
		return r;
	endfunction

	function automatic shape_t shape_lookup(input logic [CP_W-1:0] cp);
		shape_t s;
		s.hit = 1'b1;
		s.two = 1'b0;
		s.r0  = R_NONE;
		s.r1  = R_NONE;
		case (cp)
			21'h02588: s.r0 = mk_rect(0, 0, 16, 16);
			21'h02580: s.r0 = mk_rect(0, 0, 16, 8);
			21'h02584: s.r0 = mk_rect(0, 8, 16, 8);
			21'h0258C: s.r0 = mk_rect(0, 0, 8, 16);
			21'h02590: s.r0 = mk_rect(8, 0, 8, 16);
			21'h02581: s.r0 = mk_rect(0, 14, 16, 2);
			21'h02582: s.r0 = mk_rect(0, 12, 16, 4);
			21'h02583: s.r0 = mk_rect(0, 10, 16, 6);
			21'h02585: s.r0 = mk_rect(0, 6, 16, 10);
			21'h02586: s.r0 = mk_rect(0, 4, 16, 12);
			21'h02587: s.r0 = mk_rect(0, 2, 16, 14);
			21'h02589: s.r0 = mk_rect(0, 0, 14, 16);
			21'h0258A: s.r0 = mk_rect(0, 0, 12, 16);
			21'h0258B: s.r0 = mk_rect(0, 0, 10, 16);
			21'h0258D: s.r0 = mk_rect(0, 0, 6, 16);
			21'h0258E: s.r0 = mk_rect(0, 0, 4, 16);
			21'h0258F: s.r0 = mk_rect(0, 0, 2, 16);
			21'h02500: s.r0 = R_HL;
			21'h02501: s.r0 = R_HH;
			21'h02502: s.r0 = R_VL;
			21'h02503: s.r0 = R_VH;
			21'h0250C: begin s.two = 1'b1; s.r0 = R_SD; s.r1 = R_SR; end
			21'h02510: begin s.two = 1'b1; s.r0 = R_SD; s.r1 = R_SL; end
			21'h02514: begin s.two = 1'b1; s.r0 = R_SU; s.r1 = R_SR; end
			21'h02518: begin s.two = 1'b1; s.r0 = R_SU; s.r1 = R_SL; end
			21'h0251C: begin s.two = 1'b1; s.r0 = R_VL; s.r1 = R_SR; end
			21'h02524: begin s.two = 1'b1; s.r0 = R_VL; s.r1 = R_SL; end
			21'h0252C: begin s.two = 1'b1; s.r0 = R_HL; s.r1 = R_SD; end
			21'h02534: begin s.two = 1'b1; s.r0 = R_HL; s.r1 = R_SU; end
			21'h0253C: begin s.two = 1'b1; s.r0 = R_HL; s.r1 = R_VL; end
			default:   s.hit = 1'b0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== sv/box_glyph_rect_generator.sv =====
// ----------------------------------------------------------------------------
// box_glyph_rect_generator
// Turns block-element and box-drawing code points into filled rectangles in
// 1/16-pixel coordinates.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item per character cell, carrying
// code_point, column and grid_row. Output channel (out_valid/out_stall): one
// or two rectangles per item, last marks the final one. A code point that is
// not drawn procedurally gives one result with hit low, zero rectangle and
// last high. Config channel (cfg_valid/cfg_ready, always ready): index 0
// writes the cell width from the low seven data bits and saturates it above
// 64, index 1 writes the cell height and saturates it above 128. Write
// config only while the block is idle. An accepted item passes the lookup,
// multiply, add and output register stages before its first result.
// Throughput: one item per cycle for single-rectangle shapes when out_stall
// is low; a two-rectangle shape holds the output stage for both rectangles.
// Reset clears all valid bits and loads cell size 8 x 16. While out_stall is
// high the output holds, the stages behind it fill, and in_stall rises once
// every stage is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module box_glyph_rect_generator
	import bgrg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic [CP_W-1:0]      code_point,
	input  wire logic [GRID_W-1:0]    column,
	input  wire logic [GRID_W-1:0]    grid_row,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic                 hit,
	output      logic [X_W-1:0]       rect_x,
	output      logic [Y_W-1:0]       rect_y,
	output      logic [W_W-1:0]       rect_w,
	output      logic [H_W-1:0]       rect_h,
	output      logic                 last,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	logic [CW_W-1:0] cw_q;
	logic [CH_W-1:0] ch_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic sel_q;
	logic en1, en2, en3, en4;
	logic take, fin;

	shape_t            shp_s1;
	logic [GRID_W-1:0] col_s1, row_s1;

	logic                  hit_s2, two_s2;
	logic [16:0]           colcw_s2;
	logic [17:0]           rowch_s2;
	logic [11:0]           fxcw_s2 [2];
	logic [12:0]           fych_s2 [2];
	logic [W_W-1:0]        w_s2    [2];
	logic [H_W-1:0]        h_s2    [2];

	logic           hit_s3, two_s3;
	logic [X_W-1:0] x_s3 [2];
	logic [Y_W-1:0] y_s3 [2];
	logic [W_W-1:0] w_s3 [2];
	logic [H_W-1:0] h_s3 [2];

	logic           hit_s4, two_s4;
	logic [X_W-1:0] x_s4 [2];
	logic [Y_W-1:0] y_s4 [2];
	logic [W_W-1:0] w_s4 [2];
	logic [H_W-1:0] h_s4 [2];

	frect_t fr_s1 [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= CW_RESET;
			ch_q <= CH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PX_WIDTH:  cw_q <= (cfg_data[CW_W-1:0] > CW_MAX) ? CW_MAX
				                                                      : cfg_data[CW_W-1:0];
				REG_PX_HEIGHT: ch_q <= (cfg_data > CH_MAX) ? CH_MAX : cfg_data;
				default: ;
			endcase
		end
	end

	assign last = !two_s4 || sel_q;
	assign take = v_s4 && !out_stall;
	assign fin  = take && last;
	assign en4  = !v_s4 || fin;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (fin) begin
				sel_q <= 1'b0;
			end else if (take) begin
				sel_q <= 1'b1;
			end
		end
	end

	assign fr_s1[0] = shp_s1.r0;
	assign fr_s1[1] = shp_s1.r1;

	always_ff @(posedge clk) begin
		if (en1) begin
			shp_s1 <= shape_lookup(code_point);
			col_s1 <= column;
			row_s1 <= grid_row;
		end
		if (en2) begin
			hit_s2   <= shp_s1.hit;
			two_s2   <= shp_s1.two;
			colcw_s2 <= 17'(col_s1) * 17'(cw_q);
			rowch_s2 <= 18'(row_s1) * 18'(ch_q);
			for (int k = 0; k < 2; k++) begin
				fxcw_s2[k] <= 12'(fr_s1[k].x) * 12'(cw_q);
				fych_s2[k] <= 13'(fr_s1[k].y) * 13'(ch_q);
				w_s2[k]    <= 11'(fr_s1[k].w) * 11'(cw_q);
				h_s2[k]    <= 12'(fr_s1[k].h) * 12'(ch_q);
			end
		end
		if (en3) begin
			hit_s3 <= hit_s2;
			two_s3 <= two_s2;
			for (int k = 0; k < 2; k++) begin
				x_s3[k] <= {colcw_s2, 4'b0000} + X_W'(fxcw_s2[k]);
				y_s3[k] <= {rowch_s2, 4'b0000} + Y_W'(fych_s2[k]);
				w_s3[k] <= w_s2[k];
				h_s3[k] <= h_s2[k];
			end
		end
		if (en4) begin
			hit_s4 <= hit_s3;
			two_s4 <= two_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			w_s4   <= w_s3;
			h_s4   <= h_s3;
		end
	end

	always_comb begin
		out_valid = v_s4;
		hit       = hit_s4;
		rect_x    = '0;
		rect_y    = '0;
		rect_w    = '0;
		rect_h    = '0;
		if (hit_s4) begin
			rect_x = sel_q ? x_s4[1] : x_s4[0];
			rect_y = sel_q ? y_s4[1] : y_s4[0];
			rect_w = sel_q ? w_s4[1] : w_s4[0];
			rect_h = sel_q ? h_s4[1] : h_s4[0];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bgrg_checker.sv =====
// ----------------------------------------------------------------------------
// bgrg_checker
// Port-level checks of the box glyph rectangle generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrg_checker
	import bgrg_pkg::*;
(
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire logic           hit,
	input wire logic [X_W-1:0] rect_x,
	input wire logic [Y_W-1:0] rect_y,
	input wire logic [W_W-1:0] rect_w,
	input wire logic [H_W-1:0] rect_h,
	input wire logic           last
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_y)
			&& $stable(last) && $stable(hit))
		else $error("stalled item changed");

	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> last && rect_x == '0 && rect_y == '0
			&& rect_w == '0 && rect_h == '0)
		else $error("non-procedural result not blank");

	a_second_rect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && hit && last)
		else $error("second rectangle missing");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> rect_w <= 11'd1024 && rect_h <= 12'd2048)
		else $error("rectangle size out of range");

endmodule

bind box_glyph_rect_generator bgrg_checker u_bgrg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.rect_x    (rect_x),
	.rect_y    (rect_y),
	.rect_w    (rect_w),
	.rect_h    (rect_h),
	.last      (last)
);

`default_nettype wire

// ===== tb/sv/box_glyph_rect_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_glyph_rect_generator_tb
// Self-checking bench for the box glyph rectangle generator.
// ----------------------------------------------------------------------------
// A queue of character cells feeds a clocked driver; a clocked monitor builds
// the expected rectangles of every accepted cell from its own shape table and
// the current cell size, and checks each delivered rectangle against the
// oldest one waiting. A directed pass walks every drawn shape and the grid
// corners, then random phases change the cell size (limits, saturation,
// zero) and the idle and stall pattern on both channels.
// ----------------------------------------------------------------------------

module box_glyph_rect_generator_tb
	import bgrg_pkg::*;
;

	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          RANDOM_PHASES  = 8;
	localparam int          CELLS_PER_PHASE = 210;
	localparam int          GLYPH_COUNT    = 30;
	localparam int unsigned GAP_PCT[4]     = '{0, 49, 0, 27};
	localparam int unsigned STALL_PCT[4]   = '{0, 0, 49, 27};

	// rectangle in sixteenths of the cell: {x, y, w, h}, 5 bits each
	localparam logic [19:0] NO_RECT = 20'd0;
	localparam logic [19:0] LINE_H  = {5'd0, 5'd7, 5'd16, 5'd2};
	localparam logic [19:0] HEAVY_H = {5'd0, 5'd6, 5'd16, 5'd4};
	localparam logic [19:0] LINE_V  = {5'd7, 5'd0, 5'd2, 5'd16};
	localparam logic [19:0] HEAVY_V = {5'd6, 5'd0, 5'd4, 5'd16};
	localparam logic [19:0] STUB_L  = {5'd0, 5'd7, 5'd9, 5'd2};
	localparam logic [19:0] STUB_R  = {5'd7, 5'd7, 5'd9, 5'd2};
	localparam logic [19:0] STUB_U  = {5'd7, 5'd0, 5'd2, 5'd9};
	localparam logic [19:0] STUB_D  = {5'd7, 5'd7, 5'd2, 5'd9};

	typedef struct packed {
		logic [CP_W-1:0] code;
		logic            two;
		logic [19:0]     first;
		logic [19:0]     second;
	} glyph_t;

	typedef struct packed {
		logic [CP_W-1:0]   code;
		logic [GRID_W-1:0] column;
		logic [GRID_W-1:0] row;
	} cell_t;

	typedef struct packed {
		logic           hit;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [W_W-1:0] w;
		logic [H_W-1:0] h;
		logic           last;
	} rect_t;

	localparam glyph_t GLYPHS[GLYPH_COUNT] = '{
		{21'h02588, 1'b0, {5'd0, 5'd0, 5'd16, 5'd16}, NO_RECT},
		{21'h02580, 1'b0, {5'd0, 5'd0, 5'd16, 5'd8}, NO_RECT},
		{21'h02584, 1'b0, {5'd0, 5'd8, 5'd16, 5'd8}, NO_RECT},
		{21'h0258C, 1'b0, {5'd0, 5'd0, 5'd8, 5'd16}, NO_RECT},
		{21'h02590, 1'b0, {5'd8, 5'd0, 5'd8, 5'd16}, NO_RECT},
		{21'h02581, 1'b0, {5'd0, 5'd14, 5'd16, 5'd2}, NO_RECT},
		{21'h02582, 1'b0, {5'd0, 5'd12, 5'd16, 5'd4}, NO_RECT},
		{21'h02583, 1'b0, {5'd0, 5'd10, 5'd16, 5'd6}, NO_RECT},
		{21'h02585, 1'b0, {5'd0, 5'd6, 5'd16, 5'd10}, NO_RECT},
		{21'h02586, 1'b0, {5'd0, 5'd4, 5'd16, 5'd12}, NO_RECT},
		{21'h02587, 1'b0, {5'd0, 5'd2, 5'd16, 5'd14}, NO_RECT},
		{21'h02589, 1'b0, {5'd0, 5'd0, 5'd14, 5'd16}, NO_RECT},
		{21'h0258A, 1'b0, {5'd0, 5'd0, 5'd12, 5'd16}, NO_RECT},
		{21'h0258B, 1'b0, {5'd0, 5'd0, 5'd10, 5'd16}, NO_RECT},
		{21'h0258D, 1'b0, {5'd0, 5'd0, 5'd6, 5'd16}, NO_RECT},
		{21'h0258E, 1'b0, {5'd0, 5'd0, 5'd4, 5'd16}, NO_RECT},
		{21'h0258F, 1'b0, {5'd0, 5'd0, 5'd2, 5'd16}, NO_RECT},
		{21'h02500, 1'b0, LINE_H, NO_RECT},
		{21'h02501, 1'b0, HEAVY_H, NO_RECT},
		{21'h02502, 1'b0, LINE_V, NO_RECT},
		{21'h02503, 1'b0, HEAVY_V, NO_RECT},
		{21'h0250C, 1'b1, STUB_D, STUB_R},
		{21'h02510, 1'b1, STUB_D, STUB_L},
		{21'h02514, 1'b1, STUB_U, STUB_R},
		{21'h02518, 1'b1, STUB_U, STUB_L},
		{21'h0251C, 1'b1, LINE_V, STUB_R},
		{21'h02524, 1'b1, LINE_V, STUB_L},
		{21'h0252C, 1'b1, LINE_H, STUB_D},
		{21'h02534, 1'b1, LINE_H, STUB_U},
		{21'h0253C, 1'b1, LINE_H, LINE_V}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CP_W-1:0]      code_point;
	logic [GRID_W-1:0]    column;
	logic [GRID_W-1:0]    grid_row;
	logic                 out_valid;
	logic                 out_stall;
	logic                 hit;
	logic [X_W-1:0]       rect_x;
	logic [Y_W-1:0]       rect_y;
	logic [W_W-1:0]       rect_w;
	logic [H_W-1:0]       rect_h;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	cell_t       pending_cells[$];
	rect_t       rect_expect[$];
	logic        cell_taken;
	int unsigned px_width;
	int unsigned px_height;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int          cells_queued;
	int          cells_accepted;
	int          rects_checked;
	int          fallback_count;
	int          mismatches;
	int          cycles;

	box_glyph_rect_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.column     (column),
		.grid_row   (grid_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		logic [CW_W-1:0] wv;
		logic [CH_W-1:0] hv;
		wv = data[CW_W-1:0];
		hv = data[CH_W-1:0];
		case (idx)
			REG_PX_WIDTH:  px_width  = (wv > CW_MAX) ? CW_MAX : wv;
			REG_PX_HEIGHT: px_height = (hv > CH_MAX) ? CH_MAX : hv;
			default: ;
		endcase
	endfunction

	function automatic void predict_rects(cell_t c);
		glyph_t      g;
		logic [19:0] part;
		bit          found;
		rect_t       r;
		int unsigned parts;
		found = 1'b0;
		foreach (GLYPHS[i]) begin
			if (!found && GLYPHS[i].code == c.code) begin
				g = GLYPHS[i];
				found = 1'b1;
			end
		end
		if (!found) begin
			r = '0;
			r.last = 1'b1;
			rect_expect.insert(rect_expect.size(), r);
			return;
		end
		parts = g.two ? 2 : 1;
		for (int k = 0; k < parts; k++) begin
			part = (k == 0) ? g.first : g.second;
			r.hit  = 1'b1;
			r.x    = X_W'(32'(c.column) * px_width * 16 + part[19:15] * px_width);
			r.y    = Y_W'(32'(c.row) * px_height * 16 + part[14:10] * px_height);
			r.w    = W_W'(part[9:5] * px_width);
			r.h    = H_W'(part[4:0] * px_height);
			r.last = (k + 1 == parts);
			rect_expect.insert(rect_expect.size(), r);
		end
	endfunction

	function automatic cell_t random_cell();
		cell_t       c;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			c.code = GLYPHS[$urandom_range(GLYPH_COUNT - 1)].code;
		else if (sel < 75)
			c.code = CP_W'(21'h02500 + $urandom_range(8'h9F));
		else
			c.code = CP_W'($urandom);
		sel = $urandom_range(9);
		c.column = (sel == 0) ? '0 : (sel == 1) ? '1 : GRID_W'($urandom_range(1023));
		sel = $urandom_range(9);
		c.row = (sel == 0) ? '0 : (sel == 1) ? '1 : GRID_W'($urandom_range(1023));
		return c;
	endfunction

	task automatic queue_cell(cell_t c);
		pending_cells.insert(pending_cells.size(), c);
		cells_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (cells_accepted != cells_queued || rect_expect.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic report_mismatch(string what, rect_t want, rect_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s) at cycle %0d: exp hit=%0b x=%0d y=%0d w=%0d h=%0d last=%0b",
				what, cycles, want.hit, want.x, want.y, want.w, want.h, want.last,
				"\n    got hit=%0b x=%0d y=%0d w=%0d h=%0d last=%0b",
				got.hit, got.x, got.y, got.w, got.h, got.last);
	endtask

	// driver
	always @(negedge clk) begin
		cell_t c;
		if (arst_n) begin
			if (!in_valid || cell_taken) begin
				if (pending_cells.size() != 0 && $urandom_range(99) >= gap_pct) begin
					c = pending_cells.pop_front();
					in_valid   <= 1'b1;
					code_point <= c.code;
					column     <= c.column;
					grid_row   <= c.row;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		rect_t got;
		rect_t want;
		if (!arst_n) begin
			cell_taken <= 1'b0;
		end else if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rects outstanding", cycles, rect_expect.size());
			$display("[box_glyph_rect_generator] ERROR");
			$finish;
		end else begin
			cycles++;
			if (cfg_valid && cfg_ready)
				apply_size_write(cfg_index, cfg_data);
			cell_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				predict_rects('{code_point, column, grid_row});
				cells_accepted++;
			end
			if (out_valid && !out_stall) begin
				got = {hit, rect_x, rect_y, rect_w, rect_h, last};
				if (rect_expect.size() == 0) begin
					report_mismatch("unexpected", '0, got);
				end else begin
					want = rect_expect.pop_front();
					rects_checked++;
					if (!want.hit)
						fallback_count++;
					if (got.hit !== want.hit || got.x !== want.x || got.y !== want.y ||
					    got.w !== want.w || got.h !== want.h || got.last !== want.last)
						report_mismatch("field", want, got);
				end
			end
		end
	end

	initial begin
		logic [CFG_DAT_W-1:0] wdat;
		logic [CFG_DAT_W-1:0] hdat;
		cell_t                c;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		code_point     = '0;
		column         = '0;
		grid_row       = '0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_PX_WIDTH;
		cfg_data       = '0;
		px_width       = CW_RESET;
		px_height      = CH_RESET;
		gap_pct        = 0;
		stall_pct      = 0;
		cells_queued   = 0;
		cells_accepted = 0;
		rects_checked  = 0;
		fallback_count = 0;
		mismatches     = 0;
		cycles         = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// every drawn shape on the first or last grid row, at an edge or random column, reset cell size
		foreach (GLYPHS[i]) begin
			c.code   = GLYPHS[i].code;
			c.column = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : GRID_W'($urandom_range(1023));
			c.row    = (i % 2 == 0) ? '1 : '0;
			queue_cell(c);
		end
		queue_cell('{'0, '1, '1});
		queue_cell('{'1, '0, '1});
		queue_cell('{21'h02504, '1, '0});
		settle();

		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: begin wdat = 8'hFF; hdat = 8'hFF; end
				2: begin wdat = 8'd1;  hdat = 8'd1;  end
				3: begin wdat = 8'h80; hdat = 8'h00; end
				4: begin wdat = 8'd64; hdat = 8'd128; end
				default: begin
					wdat = CFG_DAT_W'($urandom_range(255));
					hdat = CFG_DAT_W'($urandom_range(255));
				end
			endcase
			write_reg(REG_PX_WIDTH, wdat);
			write_reg(REG_PX_HEIGHT, hdat);
			gap_pct   = GAP_PCT[p % 4];
			stall_pct = STALL_PCT[p % 4];
			repeat (CELLS_PER_PHASE) queue_cell(random_cell());
			settle();
		end

		$display("%0d cells over %0d cell-size phases, %0d results checked (%0d glyph fallbacks)",
			cells_accepted, RANDOM_PHASES + 1, rects_checked, fallback_count);
		$display("%0d mismatches in %0d cycles", mismatches, cycles);
		if (mismatches == 0 && rect_expect.size() == 0)
			$display("[box_glyph_rect_generator] OK");
		else
			$display("[box_glyph_rect_generator] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bgrg_pkg.sv
sv/box_glyph_rect_generator.sv
sv/bgrg_checker.sv
tb/sv/box_glyph_rect_generator_tb.sv
